>>> src/imf_pkg.sv
// Shared constants for the image median filter: register indexes, field widths,
// reset values and default size limits. No dependencies.
`timescale 1ns / 1ps

package imf_pkg;

    // Pixel and stream field widths
    localparam int PIX_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_RADIUS_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_RADIUS = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 11'd512;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 13'd512;
    localparam logic [CFG_RADIUS_W-1:0] RST_KERNEL_RADIUS = 2'd2;

    // Input item kinds carried on tuser
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_RADIUS = 3;

endpackage

>>> src/image_median_filter.sv
// Top level of the streaming zero-padded 2-D median filter: configuration
// registers, front part, request queue and back part.
// Depends on imf_pkg, imf_front, imf_cmd_fifo, imf_back.
//
//  port group   dir  contents
//  s_*          in   tdata: pixel_value[7:0]; tuser: action (1 = drain)
//  m_*          out  tdata: median_value[7:0]; tlast: frame_last
//  cfg_*        in   index 0 image_width, 1 image_height, 2 kernel_radius
//
// A pixel or drain that yields no median needs no window read. One that yields a
// median holds the input while the window of n = (2*radius+1)^2 taps is read
// from the single line-store read port.
// The back part then selects the median bit-serially, one tap per cycle and
// one pass per result bit, and loads the output register.
// Reset is synchronous; there is no clearing pass. A full output register
// stalls only the back part; the front keeps taking items that yield no
// median and stalls as soon as a median request waits in the queue.
`timescale 1ns / 1ps

module image_median_filter #(
    parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = imf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [imf_pkg::PIX_W-1:0]       s_tdata,   // pixel_value
    input  logic                            s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [imf_pkg::PIX_W-1:0]       m_tdata,   // median_value
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [imf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [imf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import imf_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int GW   = $clog2(RING);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int RDW  = $clog2(MAX_RADIUS + 1);
    localparam int SW   = $clog2(2 * MAX_RADIUS + 2);
    localparam int NMAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW   = $clog2(NMAX + 1);
    localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CMDW = 1 + GW + CW + RW;

    logic [CFG_WIDTH_W-1:0]  cfg_width_reg;
    logic [CFG_HEIGHT_W-1:0] cfg_height_reg;
    logic [CFG_RADIUS_W-1:0] cfg_radius_reg;

    logic [WW-1:0]   eff_w;
    logic [RW-1:0]   eff_h;
    logic [RDW-1:0]  eff_r;
    logic [SW-1:0]   side;
    logic [NW-1:0]   win_n;
    logic [PW-1:0]   lag;
    logic            restart;

    logic            q_push, q_pop, q_full, q_nonempty, gathering;
    logic [CMDW-1:0] q_cmd_in, q_cmd_out;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    // configuration registers; a write to any of them restarts the frame
    assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT ||
                                cfg_index == REG_KERNEL_RADIUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_IMAGE_WIDTH;
            cfg_height_reg <= RST_IMAGE_HEIGHT;
            cfg_radius_reg <= RST_KERNEL_RADIUS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                REG_KERNEL_RADIUS: cfg_radius_reg <= cfg_wdata[CFG_RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamped working values
    assign eff_w = (cfg_width_reg == '0) ? WW'(1) :
                   (32'(cfg_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_width_reg);
    assign eff_h = (cfg_height_reg == '0) ? RW'(1) :
                   (32'(cfg_height_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(cfg_height_reg);
    assign eff_r = (32'(cfg_radius_reg) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(cfg_radius_reg);
    assign side  = SW'({eff_r, 1'b1});
    assign win_n = NW'(side) * NW'(side);
    assign lag   = PW'(eff_r) * PW'(eff_w) + PW'(eff_r);

    imf_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .restart   (restart),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .lag       (lag),
        .q_full    (q_full),
        .q_nonempty(q_nonempty),
        .gathering (gathering),
        .q_push    (q_push),
        .q_cmd     (q_cmd_in),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    imf_cmd_fifo #(
        .DW(CMDW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_cmd_in),
        .pop      (q_pop),
        .pop_data (q_cmd_out),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    imf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .eff_r     (eff_r),
        .win_n     (win_n),
        .q_nonempty(q_nonempty),
        .q_cmd     (q_cmd_out),
        .q_pop     (q_pop),
        .gathering (gathering),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a request is never pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("median request queue overflow");

    // window gathering only starts from a popped request
    a_gather_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(gathering) |-> $past(q_pop))
        else $error("gather started without a request");

    // the line store is never written while a window is being read
    a_store_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        gathering |-> !mem_we)
        else $error("line store written during gather");

endmodule

>>> src/imf_cmd_fifo.sv
// Two-entry request queue between the front and back parts of the median filter.
// Depends on nothing.
`timescale 1ns / 1ps

module imf_cmd_fifo #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          full,
    output logic          nonempty
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/imf_front.sv
// Front part of the median filter: accepts pixels and drain requests, writes the
// line store, keeps the frame counters and queues one median request per output.
// Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_front #(
    parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = imf_pkg::DEF_MAX_RADIUS,
    localparam int WW   = $clog2(MAX_WIDTH + 1),
    localparam int CW   = $clog2(MAX_WIDTH),
    localparam int RW   = $clog2(MAX_HEIGHT + 1),
    localparam int RING = 2 * MAX_RADIUS + 2,
    localparam int GW   = $clog2(RING),
    localparam int AW   = $clog2(RING * MAX_WIDTH),
    localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int CMDW = 1 + GW + CW + RW
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [imf_pkg::PIX_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      restart,
    input  logic [WW-1:0]             eff_w,
    input  logic [RW-1:0]             eff_h,
    input  logic [PW-1:0]             lag,
    input  logic                      q_full,
    input  logic                      q_nonempty,
    input  logic                      gathering,
    output logic                      q_push,
    output logic [CMDW-1:0]           q_cmd,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [imf_pkg::PIX_W-1:0] mem_wdata
);
    import imf_pkg::*;

    logic [RW-1:0] in_row_reg,  out_row_reg;
    logic [CW-1:0] in_col_reg,  out_col_reg;
    logic [GW-1:0] in_ring_reg, out_ring_reg;
    logic [PW-1:0] pend_reg;

    logic accept, in_done, is_pixel, emit, last, in_col_end, out_col_end;
    logic [GW-1:0] in_ring_inc, out_ring_inc;

    // take a new item only once the back part has gathered the last window
    assign s_tready = !q_nonempty && !gathering && !q_full;
    assign accept   = s_tvalid && s_tready;

    // classify the item
    assign in_done  = (in_row_reg >= eff_h);
    assign is_pixel = !in_done && (s_tuser == ACT_PIXEL);
    assign emit     = accept && (in_done ? (out_row_reg < eff_h)
                                         : (is_pixel && (pend_reg >= lag)));
    assign in_col_end  = (WW'(in_col_reg)  == eff_w - WW'(1));
    assign out_col_end = (WW'(out_col_reg) == eff_w - WW'(1));
    assign last        = (out_row_reg == eff_h - RW'(1)) && out_col_end;

    assign in_ring_inc  = (in_ring_reg  == GW'(RING - 1)) ? '0 : in_ring_reg  + GW'(1);
    assign out_ring_inc = (out_ring_reg == GW'(RING - 1)) ? '0 : out_ring_reg + GW'(1);

    // line store write
    assign mem_we    = accept && is_pixel;
    assign mem_waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign mem_wdata = s_tdata;

    // median request
    assign q_push = emit;
    assign q_cmd  = {last, out_ring_reg, out_col_reg, out_row_reg};

    // frame counters
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_ring_reg <= '0;
            pend_reg     <= '0;
        end else if (accept) begin
            if (is_pixel) begin
                if (in_col_end) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + RW'(1);
                    in_ring_reg <= in_ring_inc;
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (is_pixel && !emit) pend_reg <= pend_reg + PW'(1);
            else if (!is_pixel && emit) pend_reg <= pend_reg - PW'(1);
            if (emit) begin
                if (last) begin
                    // frame done: back to the first position
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_ring_reg  <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_ring_reg <= '0;
                    pend_reg     <= '0;
                end else if (out_col_end) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + RW'(1);
                    out_ring_reg <= out_ring_inc;
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

endmodule

>>> src/imf_back.sv
// Back part of the median filter: holds the line store, gathers the zero-padded
// window into a rotating tap line and selects the median one bit per pass.
// Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_back #(
    parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = imf_pkg::DEF_MAX_RADIUS,
    localparam int WW   = $clog2(MAX_WIDTH + 1),
    localparam int CW   = $clog2(MAX_WIDTH),
    localparam int RW   = $clog2(MAX_HEIGHT + 1),
    localparam int RING = 2 * MAX_RADIUS + 2,
    localparam int GW   = $clog2(RING),
    localparam int AW   = $clog2(RING * MAX_WIDTH),
    localparam int RDW  = $clog2(MAX_RADIUS + 1),
    localparam int SW   = $clog2(2 * MAX_RADIUS + 2),
    localparam int NMAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int NW   = $clog2(NMAX + 1),
    localparam int CMDW = 1 + GW + CW + RW
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [WW-1:0]             eff_w,
    input  logic [RW-1:0]             eff_h,
    input  logic [RDW-1:0]            eff_r,
    input  logic [NW-1:0]             win_n,
    input  logic                      q_nonempty,
    input  logic [CMDW-1:0]           q_cmd,
    output logic                      q_pop,
    output logic                      gathering,
    input  logic                      mem_we,
    input  logic [AW-1:0]             mem_waddr,
    input  logic [imf_pkg::PIX_W-1:0] mem_wdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [imf_pkg::PIX_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import imf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_SELECT = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    localparam int RSW = RW + 2;
    localparam int CSW = WW + 2;

    logic [1:0]       state_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic             last_reg;
    logic [GW-1:0]    ring_reg;
    logic [SW-1:0]    i_reg, j_reg;
    logic [NW-1:0]    gk_reg, sk_reg, cnt_reg;
    logic             cap_reg, inb_reg;
    logic [2:0]       bit_reg;
    logic [PIX_W-1:0] res_reg;
    logic [PIX_W-1:0] win_reg  [NMAX];
    logic [PIX_W-1:0] win_next [NMAX];

    logic [PIX_W-1:0] mem [RING * MAX_WIDTH];
    logic [PIX_W-1:0] mem_q_reg;
    logic [AW-1:0]    raddr;

    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tvalid_reg, m_tlast_reg;

    logic [RW-1:0]    cmd_row;
    logic [CW-1:0]    cmd_col;
    logic [GW-1:0]    cmd_ring, start_ring, ring_inc;
    logic             cmd_last;
    logic [SW-1:0]    side;
    logic signed [RSW-1:0] tap_row;
    logic signed [CSW-1:0] tap_col;
    logic             issuing, tap_inb, shift_en, lt;
    logic [PIX_W-1:0] shift_in, trial;
    logic [NW-1:0]    total, kth;

    assign {cmd_last, cmd_ring, cmd_col, cmd_row} = q_cmd;
    assign side  = SW'({eff_r, 1'b1});
    assign kth   = win_n >> 1;
    assign q_pop = (state_reg == ST_IDLE) && q_nonempty;
    assign gathering = (state_reg == ST_GATHER);

    // first ring row of the window, radius rows above the output row
    assign start_ring = (cmd_ring >= GW'(eff_r)) ? cmd_ring - GW'(eff_r)
                                                 : cmd_ring + GW'(RING) - GW'(eff_r);
    assign ring_inc   = (ring_reg == GW'(RING - 1)) ? '0 : ring_reg + GW'(1);

    // tap position and bounds
    assign tap_row = $signed(RSW'(row_reg)) + $signed(RSW'(i_reg)) - $signed(RSW'(eff_r));
    assign tap_col = $signed(CSW'(col_reg)) + $signed(CSW'(j_reg)) - $signed(CSW'(eff_r));
    assign tap_inb = (tap_row >= 0) && (tap_row < $signed(RSW'(eff_h))) &&
                     (tap_col >= 0) && (tap_col < $signed(CSW'(eff_w)));
    assign issuing = (state_reg == ST_GATHER) && (gk_reg < win_n);
    assign raddr   = AW'(ring_reg) * AW'(MAX_WIDTH) + AW'(tap_col[CW-1:0]);

    // line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= mem[raddr];
    end

    // tap line: shift in gathered taps, rotate during selection
    assign shift_en = ((state_reg == ST_GATHER) && cap_reg) || (state_reg == ST_SELECT);
    assign shift_in = (state_reg == ST_SELECT) ? win_reg[0]
                                               : (inb_reg ? mem_q_reg : '0);

    always_comb begin
        int nxt;
        for (int k = 0; k < NMAX; k++) begin
            nxt = (k == NMAX - 1) ? 0 : k + 1;
            if (NW'(k) == win_n - NW'(1)) win_next[k] = shift_in;
            else if (k < NMAX - 1)        win_next[k] = win_reg[nxt];
            else                          win_next[k] = win_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) win_reg <= win_next;
    end

    // bit-wise selection: count taps below the trial value
    assign trial = res_reg | (PIX_W'(1) << bit_reg);
    assign lt    = (win_reg[0] < trial);
    assign total = cnt_reg + NW'(lt);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg   <= 1'b0;
        end else begin
            cap_reg <= issuing;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_nonempty) state_reg <= ST_GATHER;
                end
                ST_GATHER: begin
                    if (gk_reg == win_n && !cap_reg) state_reg <= ST_SELECT;
                end
                ST_SELECT: begin
                    if (sk_reg == win_n - NW'(1) && bit_reg == 3'd0) state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!m_tvalid_reg || m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        inb_reg <= tap_inb;
        unique case (state_reg)
            ST_IDLE: begin
                row_reg  <= cmd_row;
                col_reg  <= cmd_col;
                last_reg <= cmd_last;
                ring_reg <= start_ring;
                i_reg    <= '0;
                j_reg    <= '0;
                gk_reg   <= '0;
            end
            ST_GATHER: begin
                if (issuing) begin
                    gk_reg <= gk_reg + NW'(1);
                    if (j_reg == side - SW'(1)) begin
                        j_reg    <= '0;
                        i_reg    <= i_reg + SW'(1);
                        ring_reg <= ring_inc;
                    end else begin
                        j_reg <= j_reg + SW'(1);
                    end
                end
                bit_reg <= 3'd7;
                sk_reg  <= '0;
                cnt_reg <= '0;
                res_reg <= '0;
            end
            ST_SELECT: begin
                if (sk_reg == win_n - NW'(1)) begin
                    if (total <= kth) res_reg <= trial;
                    bit_reg <= bit_reg - 3'd1;
                    sk_reg  <= '0;
                    cnt_reg <= '0;
                end else begin
                    sk_reg  <= sk_reg + NW'(1);
                    cnt_reg <= total;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_PUSH && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= res_reg;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for image_median_filter: streams pixel and drain
// requests, predicts each median in a local model of the filter and checks it.
// Depends on imf_pkg and the image_median_filter RTL.
`timescale 1ns / 1ps

module testbench;
    import imf_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int SETTLE_CYC  = 9 * 49 + 60;

    typedef struct packed {
        logic [PIX_W-1:0] med;
        logic             last;
    } median_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata = '0;   // pixel_value
    logic                   s_tuser = 1'b0; // action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PIX_W-1:0]       m_tdata;        // median_value
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    image_median_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Local copy of the filter: registers, frame pixels and counters
    int unsigned     width_reg  = RST_IMAGE_WIDTH;
    int unsigned     height_reg = RST_IMAGE_HEIGHT;
    int unsigned     radius_reg = RST_KERNEL_RADIUS;
    logic [PIX_W-1:0] frame_pix [int];
    int unsigned     in_row, in_col, out_row, out_col;
    median_t         median_q [$];

    int unsigned items_sent, medians_seen, frames_done, errors;
    int unsigned burst_left;

    function automatic int unsigned eff_width();
        if (width_reg < 1) return 1;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 1) return 1;
        if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_counters();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endfunction

    // Median of the zero-padded window at the output position, then advance
    function automatic void emit_median();
        int unsigned w, h, n, k;
        int r, i, j, rr, cc, a, b;
        logic [PIX_W-1:0] win [49];
        logic [PIX_W-1:0] t;
        median_t e;
        w = eff_width();
        h = eff_height();
        r = radius_reg;
        n = (2 * r + 1) * (2 * r + 1);
        k = 0;
        for (i = -r; i <= r; i++) begin
            for (j = -r; j <= r; j++) begin
                rr = int'(out_row) + i;
                cc = int'(out_col) + j;
                win[k] = '0;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w) &&
                    frame_pix.exists(rr * DEF_MAX_WIDTH + cc))
                    win[k] = frame_pix[rr * DEF_MAX_WIDTH + cc];
                k++;
            end
        end
        for (a = 1; a < int'(n); a++) begin
            b = a;
            while (b > 0 && win[b-1] > win[b]) begin
                t = win[b]; win[b] = win[b-1]; win[b-1] = t;
                b--;
            end
        end
        e.med  = win[n/2];
        e.last = (out_row == h - 1) && (out_col == w - 1);
        median_q.push_back(e);
        if (e.last) begin
            restart_counters();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic void predict_request(input logic act, input logic [PIX_W-1:0] pix);
        int unsigned w, h, r;
        longint kin, kout;
        w = eff_width();
        h = eff_height();
        r = radius_reg;
        if (in_row >= h) begin
            if (out_row < h) emit_median();
            return;
        end
        if (act == ACT_DRAIN) return;
        frame_pix[in_row * DEF_MAX_WIDTH + in_col] = pix;
        kin  = longint'(in_row) * w + in_col;
        kout = longint'(out_row) * w + out_col;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (kin >= kout + longint'(r) * w + r) emit_median();
    endfunction

    function automatic bit frame_idle();
        return in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0;
    endfunction

    // Send one request; sender works in bursts with random gaps
    task automatic send_request(input logic act, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        predict_request(act, pix);
        items_sent++;
    endtask

    // Wait until every expected median is out and the back part is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Write all three registers on consecutive cycles while idle
    task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned r);
        wait_idle();
        cfg_we <= 1'b1; cfg_index <= REG_IMAGE_WIDTH; cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT; cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_index <= REG_KERNEL_RADIUS; cfg_wdata <= CFG_DATA_W'(r);
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg  = w & 11'h7FF;
        height_reg = h & 13'h1FFF;
        radius_reg = r & 2'h3;
        restart_counters();
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int mode, input logic [PIX_W-1:0] base);
        case (mode)
            0: return PIX_W'($urandom);
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return base ^ PIX_W'($urandom_range(0, 3));
            default: return base;
        endcase
    endfunction

    // Full frame: pixels with stray drains, then drains and stray pixels until the frame ends
    task automatic stream_frame(input int mode, input int drain_pct);
        int unsigned total, p;
        logic [PIX_W-1:0] base;
        base  = PIX_W'($urandom);
        total = eff_width() * eff_height();
        for (p = 0; p < total; p++) begin
            if ($urandom_range(0, 99) < drain_pct) send_request(ACT_DRAIN, PIX_W'($urandom));
            send_request(ACT_PIXEL, pick_pixel(mode, base));
        end
        while (!frame_idle()) begin
            // a pixel after the frame is complete acts as a drain
            if ($urandom_range(0, 7) == 0) send_request(ACT_PIXEL, PIX_W'($urandom));
            else send_request(ACT_DRAIN, PIX_W'($urandom));
        end
        frames_done++;
    endtask

    // Drains before the frame is complete yield nothing (reset sizes)
    task automatic test_early_drain();
        int i;
        for (i = 0; i < 3; i++) send_request(ACT_DRAIN, 8'hFF);
        for (i = 0; i < 8; i++) send_request(ACT_PIXEL, PIX_W'(i * 37));
        send_request(ACT_DRAIN, 8'h00);
    endtask

    // Small frame of extremes, extra drains with nothing pending
    task automatic test_extremes();
        int i;
        set_frame(3, 3, 1);
        for (i = 0; i < 9; i++) send_request(ACT_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        send_request(ACT_PIXEL, 8'h55);
        while (!frame_idle()) send_request(ACT_DRAIN, 8'hAA);
        send_request(ACT_DRAIN, 8'h00);
        send_request(ACT_DRAIN, 8'hFF);
        frames_done++;
    endtask

    task automatic test_radius_range();
        set_frame(4, 2, 0);
        stream_frame(0, 0);
        set_frame(7, 5, 3);
        stream_frame(0, 10);
    endtask

    // Out-of-range sizes are clamped; large sizes only partly streamed
    task automatic test_clamps();
        int i;
        set_frame(0, 0, 3);
        stream_frame(0, 20);
        set_frame(2047, 1, 0);
        for (i = 0; i < 40; i++) send_request(ACT_PIXEL, PIX_W'($urandom));
        set_frame(1, 8191, 0);
        for (i = 0; i < 40; i++) send_request(ACT_PIXEL, PIX_W'($urandom));
        set_frame(1024, 4096, 1);
        for (i = 0; i < 20; i++) send_request(ACT_PIXEL, PIX_W'($urandom));
    endtask

    // Sender stops mid-frame until all medians are out, then resumes
    task automatic test_pause();
        int i;
        set_frame(6, 6, 1);
        for (i = 0; i < 20; i++) send_request(ACT_PIXEL, PIX_W'($urandom));
        wait_idle();
        stream_frame(0, 5);
    endtask

    task automatic test_random_frames();
        int unsigned w, h, r, sel;
        int i, cut;
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            r = (sel == 0) ? 3 : $urandom_range(0, 2);
            w = (sel == 1) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            h = (sel == 1) ? $urandom_range(1, 3) : $urandom_range(1, 9);
            set_frame(w, h, r);
            if ($urandom_range(0, 7) == 0) begin
                // aborted frame: partly streamed, then reconfigured
                cut = $urandom_range(0, w * h);
                for (i = 0; i < cut; i++) send_request(ACT_PIXEL, PIX_W'($urandom));
            end else begin
                stream_frame($urandom_range(0, 3), $urandom_range(0, 15));
                if ($urandom_range(0, 2) == 0) stream_frame($urandom_range(0, 3), 0);
            end
        end
    endtask

    // Receiver stall pattern: ready duty cycle is redrawn periodically from 100, 70, 30 or 5 percent
    int unsigned ready_pct = 100;
    int unsigned stall_cnt = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 70;
                2: ready_pct <= 30;
                default: ready_pct <= 5;
            endcase
        end
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        median_t e;
        if (aresetn && m_tvalid && m_tready) begin
            medians_seen++;
            if (median_q.size() == 0) begin
                $display("%0t: unexpected median %0d last %0b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = median_q.pop_front();
                if (m_tdata !== e.med) begin
                    $display("%0t: median expected %0d actual %0d", $time, e.med, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("%0t: timeout, %0d medians still expected", $time, median_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        restart_counters();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_early_drain();
        test_extremes();
        test_radius_range();
        test_clamps();
        test_pause();
        test_random_frames();
        wait_idle();
        $display("Covered %0d requests, %0d medians, %0d complete frames", items_sent,
                 medians_seen, frames_done);
        $display("radius 0..3, clamped sizes, early and idle drains, mid-frame restarts");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
